FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the view matrix RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/lav_pkg.sv
// Widths, constants and the Q20.32 to Q16.16 conversion for the view matrix.
// No dependencies.
package lav_pkg;

    localparam int VEC_W     = 50;
    localparam int NRM_W     = 30;
    localparam int NORM_POS  = 29;
    localparam int SUM_W     = 62;
    localparam int SQ_STEPS  = SUM_W / 2;
    localparam int LEN_W     = 31;
    localparam int Q_W       = 17;
    localparam int DIV_STEPS = Q_W;
    localparam int REM_W     = 48;
    localparam int UNIT_W    = 18;
    localparam int SIDE_W    = 192;
    localparam int QIN_W     = 52;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    // round half up, then saturate to 32 bits
    function automatic logic [31:0] to_q16(input logic [QIN_W-1:0] v);
        logic [QIN_W:0]    t;
        logic [QIN_W-16:0] r;
        logic [31:0]       res;
        t = {v[QIN_W-1], v} + (QIN_W+1)'(32'd32768);
        r = t[QIN_W:16];
        if (!r[QIN_W-16] && (|r[QIN_W-17:31])) begin
            res = 32'h7FFF_FFFF;
        end else if (r[QIN_W-16] && !(&r[QIN_W-17:31])) begin
            res = 32'h8000_0000;
        end else begin
            res = r[31:0];
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/look_at_view_matrix.sv
// Look-at view matrix: top level with cross products, translation and serializer.
// Depends on lav_pkg, lav_unit and assert_macros.svh.
//
// Input channel: i_in_valid / o_in_ready carry one word of eye, target and up
// vectors (signed Q16.16). Output channel: o_out_valid / i_out_ready carry the
// sixteen matrix elements of each input word in column-major order, tagged
// with element index, last flag and degenerate flag.
// Pipeline: the word passes 115 register stages (two normalizer pipelines of
// 54 stages, six arithmetic stages and the output register) before its first
// element is offered. Throughput: the output serializer emits one element per
// cycle while the receiver is ready, so each word holds it for sixteen elements;
// the pipeline takes a new word every cycle while the serializer is free or
// finishing its last element.
// When the receiver stalls, the whole pipeline holds; nothing is dropped.
// A zero-length axis gives sixteen zero elements with degenerate set.
// Reset (synchronous, active low) clears all valid bits and the serializer.
`include "assert_macros.svh"
module look_at_view_matrix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_eye_x,
    input  logic [31:0] i_eye_y,
    input  logic [31:0] i_eye_z,
    input  logic [31:0] i_target_x,
    input  logic [31:0] i_target_y,
    input  logic [31:0] i_target_z,
    input  logic [31:0] i_up_x,
    input  logic [31:0] i_up_y,
    input  logic [31:0] i_up_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_element_index,
    output logic [31:0] o_element_value,
    output logic        o_last_element,
    output logic        o_degenerate
);
    localparam int VEC_W  = lav_pkg::VEC_W;
    localparam int UNIT_W = lav_pkg::UNIT_W;
    localparam int SIDE_W = lav_pkg::SIDE_W;
    localparam int QIN_W  = lav_pkg::QIN_W;

    logic en;
    logic r_busy;
    logic [3:0] r_cnt;

    assign en = !r_busy || (i_out_ready && (r_cnt == 4'd15));
    assign o_in_ready = en;

    // z axis
    logic [2:0][VEC_W-1:0] z_in;
    logic                  z_valid;
    logic                  z_ok;
    logic [2:0][UNIT_W-1:0] z_u;
    logic [SIDE_W-1:0]     z_side;

    assign z_in[0] = VEC_W'($signed(i_eye_x)) - VEC_W'($signed(i_target_x));
    assign z_in[1] = VEC_W'($signed(i_eye_y)) - VEC_W'($signed(i_target_y));
    assign z_in[2] = VEC_W'($signed(i_eye_z)) - VEC_W'($signed(i_target_z));

    lav_unit u_zunit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_v     (z_in),
        .i_side  ({i_eye_x, i_eye_y, i_eye_z, i_up_x, i_up_y, i_up_z}),
        .o_valid (z_valid),
        .o_ok    (z_ok),
        .o_u     (z_u),
        .o_side  (z_side)
    );

    logic signed [31:0] ze [3];
    logic signed [31:0] zup [3];
    logic signed [UNIT_W-1:0] zs [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            ze[j]  = $signed(z_side[191-32*j -: 32]);
            zup[j] = $signed(z_side[95-32*j -: 32]);
            zs[j]  = $signed(z_u[j]);
        end
    end

    // up cross z
    logic                     r1_v, r2_v;
    logic signed [VEC_W-1:0]  r1_p [6];
    logic signed [31:0]       r1_eye [3], r2_eye [3];
    logic signed [UNIT_W-1:0] r1_zu [3], r2_zu [3];
    logic                     r1_ok, r2_ok;
    logic [2:0][VEC_W-1:0]    r2_c;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p[0] <= zup[1] * zs[2];
            r1_p[1] <= zup[2] * zs[1];
            r1_p[2] <= zup[2] * zs[0];
            r1_p[3] <= zup[0] * zs[2];
            r1_p[4] <= zup[0] * zs[1];
            r1_p[5] <= zup[1] * zs[0];
            r1_eye  <= ze;
            r1_zu   <= zs;
            r1_ok   <= z_ok;
            r2_c[0] <= r1_p[0] - r1_p[1];
            r2_c[1] <= r1_p[2] - r1_p[3];
            r2_c[2] <= r1_p[4] - r1_p[5];
            r2_eye  <= r1_eye;
            r2_zu   <= r1_zu;
            r2_ok   <= r1_ok;
        end
    end

    // x axis
    logic                   x_valid;
    logic                   x_ok;
    logic [2:0][UNIT_W-1:0] x_u;
    logic [SIDE_W-1:0]      x_side;

    lav_unit u_xunit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_v     (r2_c),
        .i_side  (SIDE_W'({r2_eye[0], r2_eye[1], r2_eye[2],
                           r2_zu[0], r2_zu[1], r2_zu[2], r2_ok})),
        .o_valid (x_valid),
        .o_ok    (x_ok),
        .o_u     (x_u),
        .o_side  (x_side)
    );

    logic signed [31:0]       xe [3];
    logic signed [UNIT_W-1:0] xz [3];
    logic signed [UNIT_W-1:0] xs [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            xe[j] = $signed(x_side[150-32*j -: 32]);
            xz[j] = $signed(x_side[54-18*j -: 18]);
            xs[j] = $signed(x_u[j]);
        end
    end

    // y axis and translation
    logic                     r3_v, r4_v, r5_v, r6_v;
    logic signed [35:0]       r3_py [6];
    logic signed [VEC_W-1:0]  r3_px [3], r3_pz [3];
    logic signed [31:0]       r3_eye [3], r4_eye [3];
    logic signed [UNIT_W-1:0] r3_xu [3], r4_xu [3], r5_xu [3], r6_xu [3];
    logic signed [UNIT_W-1:0] r3_zu [3], r4_zu [3], r5_zu [3], r6_zu [3];
    logic                     r3_ok, r4_ok, r5_ok, r6_ok;
    logic [31:0]              r4_my [3], r5_my [3], r6_my [3];
    logic [QIN_W-1:0]         r4_sx, r4_sz;
    logic [31:0]              r5_m12, r5_m14, r6_m12, r6_m14;
    logic signed [QIN_W-1:0]  r5_pe [3];
    logic [QIN_W-1:0]         r6_sy;
    logic signed [QIN_W-1:0]  n_y [3];

    always_comb begin
        n_y[0] = r3_py[0] - r3_py[1];
        n_y[1] = r3_py[2] - r3_py[3];
        n_y[2] = r3_py[4] - r3_py[5];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_py[0] <= xz[1] * xs[2];
            r3_py[1] <= xz[2] * xs[1];
            r3_py[2] <= xz[2] * xs[0];
            r3_py[3] <= xz[0] * xs[2];
            r3_py[4] <= xz[0] * xs[1];
            r3_py[5] <= xz[1] * xs[0];
            for (int j = 0; j < 3; j++) begin
                r3_px[j] <= xe[j] * xs[j];
                r3_pz[j] <= xe[j] * xz[j];
                r4_my[j] <= lav_pkg::to_q16(n_y[j]);
                r5_pe[j] <= r4_eye[j] * $signed(r4_my[j]);
            end
            r3_eye <= xe;
            r3_xu  <= xs;
            r3_zu  <= xz;
            r3_ok  <= x_ok && x_side[0];

            r4_sx  <= -(QIN_W'(r3_px[0]) + QIN_W'(r3_px[1]) + QIN_W'(r3_px[2]));
            r4_sz  <= -(QIN_W'(r3_pz[0]) + QIN_W'(r3_pz[1]) + QIN_W'(r3_pz[2]));
            r4_eye <= r3_eye;
            r4_xu  <= r3_xu;
            r4_zu  <= r3_zu;
            r4_ok  <= r3_ok;

            r5_m12 <= lav_pkg::to_q16(r4_sx);
            r5_m14 <= lav_pkg::to_q16(r4_sz);
            r5_my  <= r4_my;
            r5_xu  <= r4_xu;
            r5_zu  <= r4_zu;
            r5_ok  <= r4_ok;

            r6_sy  <= -(r5_pe[0] + r5_pe[1] + r5_pe[2]);
            r6_m12 <= r5_m12;
            r6_m14 <= r5_m14;
            r6_my  <= r5_my;
            r6_xu  <= r5_xu;
            r6_zu  <= r5_zu;
            r6_ok  <= r5_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (en) begin
            r1_v <= z_valid;
            r2_v <= r1_v;
            r3_v <= x_valid;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // serializer
    logic [31:0] n_mat [16];
    logic [31:0] r_mat [16];
    logic        r_deg;

    always_comb begin
        for (int e = 0; e < 16; e++) n_mat[e] = '0;
        if (r6_ok) begin
            for (int j = 0; j < 3; j++) begin
                n_mat[4*j]     = 32'(r6_xu[j]);
                n_mat[4*j + 1] = r6_my[j];
                n_mat[4*j + 2] = 32'(r6_zu[j]);
            end
            n_mat[12] = r6_m12;
            n_mat[13] = lav_pkg::to_q16(r6_sy);
            n_mat[14] = r6_m14;
            n_mat[15] = lav_pkg::ONE_Q16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (en) begin
            r_busy <= r6_v;
            r_cnt  <= '0;
        end else if (i_out_ready) begin
            r_cnt <= r_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r6_v) begin
            r_mat <= n_mat;
            r_deg <= !r6_ok;
        end
    end

    assign o_out_valid     = r_busy;
    assign o_element_index = r_cnt;
    assign o_element_value = r_mat[r_cnt];
    assign o_last_element  = r_cnt == 4'd15;
    assign o_degenerate    = r_deg;

    `ASSERT_IMPLY(a_stall_blocks_input, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)
    `ASSERT_IMPLY(a_degenerate_zero, i_clk, i_rst_n, o_out_valid && o_degenerate, o_element_value == 32'h0)
    `ASSERT_NEXT(a_burst_continues, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last_element, o_out_valid)
    `ASSERT_IMPLY(a_corner_one, i_clk, i_rst_n, o_out_valid && !o_degenerate && o_last_element, o_element_value == lav_pkg::ONE_Q16)

endmodule

FILE: hw/rtl/lav_unit.sv
// Pipelined vector normalizer: block-normalize, sum of squares, square root, divide.
// Depends on lav_pkg. Carries a sideband word with each vector.
module lav_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [2:0][lav_pkg::VEC_W-1:0]        i_v,
    input  logic [lav_pkg::SIDE_W-1:0]            i_side,
    output logic                                  o_valid,
    output logic                                  o_ok,
    output logic [2:0][lav_pkg::UNIT_W-1:0]       o_u,
    output logic [lav_pkg::SIDE_W-1:0]            o_side
);
    localparam int VEC_W  = lav_pkg::VEC_W;
    localparam int NRM_W  = lav_pkg::NRM_W;
    localparam int SUM_W  = lav_pkg::SUM_W;
    localparam int LEN_W  = lav_pkg::LEN_W;
    localparam int REM_W  = lav_pkg::REM_W;
    localparam int Q_W    = lav_pkg::Q_W;
    localparam int SQN    = lav_pkg::SQ_STEPS;
    localparam int DVN    = lav_pkg::DIV_STEPS;
    localparam int META_W = lav_pkg::SIDE_W + 4;
    localparam int LAT    = 5 + SQN + DVN + 1;

    logic              r_mv   [LAT];
    logic [META_W-1:0] r_meta [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_mv[k] <= 1'b0;
        end else if (i_en) begin
            r_mv[0] <= i_valid;
            for (int k = 1; k < LAT; k++) r_mv[k] <= r_mv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meta[0] <= {i_side, i_v[2][VEC_W-1], i_v[1][VEC_W-1], i_v[0][VEC_W-1],
                          |i_v};
            for (int k = 1; k < LAT; k++) r_meta[k] <= r_meta[k-1];
        end
    end

    // magnitudes and largest
    logic [2:0][VEC_W-1:0] n_mag;
    logic [VEC_W-1:0]      n_max;
    logic [2:0][VEC_W-1:0] r1_mag;
    logic [VEC_W-1:0]      r1_max;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_mag[j] = i_v[j][VEC_W-1] ? (~i_v[j] + VEC_W'(1)) : i_v[j];
        end
        n_max = n_mag[0];
        if (n_mag[1] > n_max) n_max = n_mag[1];
        if (n_mag[2] > n_max) n_max = n_mag[2];
    end

    // leading one and shift
    logic [5:0]            n_pos;
    logic                  r2_right;
    logic [5:0]            r2_sh;
    logic [2:0][VEC_W-1:0] r2_mag;

    always_comb begin
        n_pos = '0;
        for (int b = 0; b < VEC_W; b++) begin
            if (r1_max[b]) n_pos = 6'(b);
        end
    end

    logic [2:0][NRM_W-1:0] r3_a;
    logic [2:0][NRM_W-1:0] r4_a;
    logic [2:0][2*NRM_W-1:0] r4_sq;
    logic [2:0][NRM_W-1:0] r5_a;
    logic [SUM_W-1:0]      r5_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag   <= n_mag;
            r1_max   <= n_max;
            r2_right <= n_pos >= 6'(lav_pkg::NORM_POS);
            r2_sh    <= (n_pos >= 6'(lav_pkg::NORM_POS)) ? n_pos - 6'(lav_pkg::NORM_POS)
                                                         : 6'(lav_pkg::NORM_POS) - n_pos;
            r2_mag   <= r1_mag;
            for (int j = 0; j < 3; j++) begin
                r3_a[j]  <= r2_right ? NRM_W'(r2_mag[j] >> r2_sh)
                                     : NRM_W'(r2_mag[j] << r2_sh);
                r4_sq[j] <= r3_a[j] * r3_a[j];
            end
            r4_a   <= r3_a;
            r5_a   <= r4_a;
            r5_sum <= SUM_W'(r4_sq[0]) + SUM_W'(r4_sq[1]) + SUM_W'(r4_sq[2]);
        end
    end

    // square root, one result bit per stage
    logic [SUM_W-1:0]      r_sn [SQN];
    logic [SUM_W-1:0]      r_sr [SQN];
    logic [2:0][NRM_W-1:0] r_sa [SQN];

    for (genvar k = 0; k < SQN; k++) begin : g_sq
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQN - 1 - k));
        logic [SUM_W-1:0]      p_n;
        logic [SUM_W-1:0]      p_r;
        logic [2:0][NRM_W-1:0] p_a;
        logic [SUM_W-1:0]      trial;
        if (k == 0) begin : g_first
            assign p_n = r5_sum;
            assign p_r = '0;
            assign p_a = r5_a;
        end else begin : g_next
            assign p_n = r_sn[k-1];
            assign p_r = r_sr[k-1];
            assign p_a = r_sa[k-1];
        end
        assign trial = p_r + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sa[k] <= p_a;
                if (p_n >= trial) begin
                    r_sn[k] <= p_n - trial;
                    r_sr[k] <= (p_r >> 1) + BIT;
                end else begin
                    r_sn[k] <= p_n;
                    r_sr[k] <= p_r >> 1;
                end
            end
        end
    end

    // restoring divide, one quotient bit per stage, three lanes
    logic [2:0][REM_W-1:0] r_dr [DVN];
    logic [2:0][Q_W-1:0]   r_dq [DVN];
    logic [LEN_W-1:0]      r_dl [DVN];

    for (genvar k = 0; k < DVN; k++) begin : g_dv
        localparam int SH = DVN - 1 - k;
        logic [2:0][REM_W-1:0] p_rem;
        logic [2:0][Q_W-1:0]   p_q;
        logic [LEN_W-1:0]      p_l;
        logic [REM_W-1:0]      dsr;
        if (k == 0) begin : g_first
            for (genvar j = 0; j < 3; j++) begin : g_ln
                assign p_rem[j] = REM_W'({r_sa[SQN-1][j], 16'h0000});
            end
            assign p_q = '0;
            assign p_l = r_sr[SQN-1][LEN_W-1:0];
        end else begin : g_next
            assign p_rem = r_dr[k-1];
            assign p_q   = r_dq[k-1];
            assign p_l   = r_dl[k-1];
        end
        assign dsr = REM_W'(p_l) << SH;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dl[k] <= p_l;
                for (int j = 0; j < 3; j++) begin
                    if (p_rem[j] >= dsr) begin
                        r_dr[k][j] <= p_rem[j] - dsr;
                        r_dq[k][j] <= p_q[j] | (Q_W'(1) << SH);
                    end else begin
                        r_dr[k][j] <= p_rem[j];
                        r_dq[k][j] <= p_q[j];
                    end
                end
            end
        end
    end

    logic [2:0][lav_pkg::UNIT_W-1:0] r_u;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_u[j] <= r_meta[LAT-2][1+j] ? (~{1'b0, r_dq[DVN-1][j]} + 1'b1)
                                              : {1'b0, r_dq[DVN-1][j]};
            end
        end
    end

    assign o_valid = r_mv[LAT-1];
    assign o_ok    = r_meta[LAT-1][0];
    assign o_u     = r_u;
    assign o_side  = r_meta[LAT-1][META_W-1:4];

endmodule

FILE: test/look_at_view_matrix_tb.sv
// Testbench for look_at_view_matrix: drives eye/target/up words, predicts the
// sixteen view matrix elements per word and checks them. Depends on the RTL only.
`timescale 1ns / 1ps
module look_at_view_matrix_tb;

    typedef struct packed {
        logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
    } t_camera;

    typedef struct packed {
        logic [3:0]  idx;
        logic [31:0] value;
        logic        last;
        logic        degen;
    } t_element;

    typedef longint t_vec3 [3];

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    t_camera     cam = '0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic [3:0]  o_element_index;
    logic [31:0] o_element_value;
    logic        o_last_element;
    logic        o_degenerate;

    t_camera  pending_cams[$];
    t_element expected_elems[$];
    int       errors = 0;
    int       words_in = 0;
    int       elems_out = 0;
    int       degen_seen = 0;
    int       cycle = 0;
    int       hold_cnt = 0;
    bit       hold_done = 0;
    bit       in_taken = 0;

    look_at_view_matrix DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_eye_x(cam.ex), .i_eye_y(cam.ey), .i_eye_z(cam.ez),
        .i_target_x(cam.tx), .i_target_y(cam.ty), .i_target_z(cam.tz),
        .i_up_x(cam.ux), .i_up_y(cam.uy), .i_up_z(cam.uz),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_element_index(o_element_index), .o_element_value(o_element_value),
        .o_last_element(o_last_element), .o_degenerate(o_degenerate)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit normalize(input t_vec3 v, output t_vec3 u);
        longint unsigned mag[3];
        longint unsigned m;
        longint unsigned sum;
        longint unsigned len;
        longint          q;
        m = 0;
        sum = 0;
        u = '{0, 0, 0};
        for (int i = 0; i < 3; i++) begin
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return 0;
        while (m >= (64'd1 << 30)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (m < (64'd1 << 29)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = longint'((mag[i] << 16) / len);
            u[i] = (v[i] < 0) ? -q : q;
        end
        return 1;
    endfunction

    function automatic longint round_sat(input longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    task automatic predict_view(input t_camera c);
        t_vec3  eye, tgt, up, d, cr, zu, xu;
        longint mat[16];
        bit     ok;
        t_element e;
        eye = '{longint'($signed(c.ex)), longint'($signed(c.ey)), longint'($signed(c.ez))};
        tgt = '{longint'($signed(c.tx)), longint'($signed(c.ty)), longint'($signed(c.tz))};
        up  = '{longint'($signed(c.ux)), longint'($signed(c.uy)), longint'($signed(c.uz))};
        for (int i = 0; i < 3; i++) d[i] = eye[i] - tgt[i];
        for (int i = 0; i < 16; i++) mat[i] = 0;
        ok = normalize(d, zu);
        if (ok) begin
            cr[0] = up[1] * zu[2] - up[2] * zu[1];
            cr[1] = up[2] * zu[0] - up[0] * zu[2];
            cr[2] = up[0] * zu[1] - up[1] * zu[0];
            ok = normalize(cr, xu);
        end
        if (ok) begin
            mat[0] = xu[0]; mat[4] = xu[1]; mat[8] = xu[2];
            mat[2] = zu[0]; mat[6] = zu[1]; mat[10] = zu[2];
            mat[1] = round_sat(zu[1] * xu[2] - zu[2] * xu[1]);
            mat[5] = round_sat(zu[2] * xu[0] - zu[0] * xu[2]);
            mat[9] = round_sat(zu[0] * xu[1] - zu[1] * xu[0]);
            mat[12] = round_sat(-(eye[0] * mat[0] + eye[1] * mat[4] + eye[2] * mat[8]));
            mat[13] = round_sat(-(eye[0] * mat[1] + eye[1] * mat[5] + eye[2] * mat[9]));
            mat[14] = round_sat(-(eye[0] * mat[2] + eye[1] * mat[6] + eye[2] * mat[10]));
            mat[15] = 65536;
        end
        for (int i = 0; i < 16; i++) begin
            e.idx = 4'(i);
            e.value = mat[i][31:0];
            e.last = (i == 15);
            e.degen = !ok;
            expected_elems.push_back(e);
        end
    endtask

    function automatic logic [31:0] rand_small();
        return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endfunction

    function automatic t_camera rand_camera();
        t_camera c;
        int      k;
        int      kind;
        kind = $urandom_range(0, 9);
        c = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
        if (kind <= 4) begin
            c = {rand_small(), rand_small(), rand_small(), rand_small(), rand_small(),
                 rand_small(), rand_small(), rand_small(), rand_small()};
        end else if (kind == 7) begin
            c.tx = c.ex; c.ty = c.ey; c.tz = c.ez;
        end else if (kind == 8) begin
            c.ex = rand_small(); c.ey = rand_small(); c.ez = rand_small();
            c.tx = rand_small(); c.ty = rand_small(); c.tz = rand_small();
            k = $urandom_range(0, 6) - 3;
            c.ux = 32'(k) * (c.ex - c.tx);
            c.uy = 32'(k) * (c.ey - c.ty);
            c.uz = 32'(k) * (c.ez - c.tz);
        end
        return c;
    endfunction

    // sender: may offer a new word at falling edge once the previous one is taken
    always @(negedge i_clk) begin
        cycle++;
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            if (pending_cams.size() > 0 &&
                ((cycle > 3000 && cycle < 6000) || $urandom_range(0, 99) >= 22)) begin
                cam <= pending_cams.pop_front();
                i_in_valid <= 1;
            end else begin
                i_in_valid <= 0;
            end
        end
        in_taken = 0;
    end

    // receiver with one long hold-off to back up the pipeline
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 0;
        end else if (!hold_done && elems_out >= 800) begin
            hold_done = 1;
            hold_cnt = 500;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= (cycle > 3000 && cycle < 6000) || $urandom_range(0, 99) >= 22;
        end
    end

    always @(posedge i_clk) begin
        t_element e;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_view(cam);
            words_in++;
            in_taken = 1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            elems_out++;
            if (o_degenerate) degen_seen++;
            if (expected_elems.size() == 0) begin
                $error("unexpected word: index %0d value %h", o_element_index, o_element_value);
                errors++;
            end else begin
                e = expected_elems.pop_front();
                if (o_element_index !== e.idx) begin
                    $error("element_index: expected %0d actual %0d", e.idx, o_element_index);
                    errors++;
                end
                if (o_element_value !== e.value) begin
                    $error("element_value: expected %h actual %h", e.value, o_element_value);
                    errors++;
                end
                if (o_last_element !== e.last) begin
                    $error("last_element: expected %b actual %b", e.last, o_last_element);
                    errors++;
                end
                if (o_degenerate !== e.degen) begin
                    $error("degenerate: expected %b actual %b", e.degen, o_degenerate);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_camera c;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        // directed: plain camera, degenerate axes, extremes
        pending_cams.push_back({32'h0, 32'h0, 32'h0005_0000, 96'h0,
                                32'h0, 32'h0001_0000, 32'h0});
        pending_cams.push_back({32'h0003_0000, 32'h0002_0000, 32'h0001_0000,
                                32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000});
        pending_cams.push_back({32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h0, 32'h0001_0000, 32'h0});
        pending_cams.push_back({32'h0, 32'h0, 32'h0004_0000, 96'h0, 64'h0, 32'h0002_0000});
        pending_cams.push_back({32'h0001_0000, 32'h0, 32'h0, 96'h0, 96'h0});
        pending_cams.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h7FFF_FFFF, 32'h0});
        pending_cams.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
        pending_cams.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h7FFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h0, 32'h0, 32'h7FFF_FFFF});
        pending_cams.push_back({32'h0000_0001, 32'h0, 32'h0, 96'h0,
                                32'h0, 32'hFFFF_FFFF, 32'h0});
        pending_cams.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                96'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        pending_cams.push_back({32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0,
                                32'h0, 32'h0, 32'h8000_0000});
        for (int i = 0; i < 8; i++) pending_cams.push_back(rand_camera());
        // sender pause: drain completely before the random part
        do @(posedge i_clk);
        while (pending_cams.size() != 0 || i_in_valid || expected_elems.size() != 0);
        for (int i = 0; i < 330; i++) pending_cams.push_back(rand_camera());
        do @(posedge i_clk);
        while (pending_cams.size() != 0 || i_in_valid || expected_elems.size() != 0);
        repeat (200) @(posedge i_clk);
        $display("%0d camera words in, %0d matrix elements checked, %0d degenerate",
                 words_in, elems_out, degen_seen);
        if (errors == 0 && expected_elems.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
